[rtl/mdc_pkg.sv]
// mdc_pkg: grid limits, command and direction codes, payload structs and the
// visited-bitmap request struct for the maze carver.
// No dependencies; compiled first.
package mdc_pkg;

  // Grid limits and derived widths
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = XW + YW;
  localparam int CNT_W      = AW + 1;
  localparam int CFG_W      = 7;

  // Command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DRAW    = 1'b1;

  // Direction codes (also the side opened)
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [1:0] direction;
  } in_item_t;

  typedef struct packed {
    logic          carved;
    logic [XW-1:0] from_x;
    logic [YW-1:0] from_y;
    logic [1:0]    open_side;
    logic          done_res;
  } out_item_t;

  // One access to the visited bitmap, one row per entry
  typedef struct packed {
    logic                 clr;
    logic                 rd_en;
    logic [YW-1:0]        rd_row;
    logic                 wr_en;
    logic [YW-1:0]        wr_row;
    logic [MAX_WIDTH-1:0] wr_data;
  } vis_req_t;

endpackage

[rtl/maze_dfs_carver.sv]
// maze_dfs_carver: randomized depth-first maze carver (recursive backtracker)
// with an explicit cell stack in RAM and a row-organised visited bitmap.
// Depends on mdc_pkg, mdc_ram and mdc_visited.
//
//   channel | ports                         | direction | meaning
//   --------+-------------------------------+-----------+---------------------------
//   in      | in_valid, in_stall, in_data   | input     | restart or direction draw
//   out     | out_valid, out_stall, out_data| output    | one result per command
//   cfg     | cfg_we, cfg_index, cfg_data   | input     | grid width / height writes
//
// Steps: a draw is accepted, does the bitmap read-modify-write and the
// neighbour check of the top cell, then posts (no read-modify-write if the
// drawn neighbour is off the grid, only the posting on an empty stack); a
// restart is accepted, checks, posts. Each backtrack pop adds a stack read and
// a check, which reads three rows through the bitmap's single read port. Reset
// is synchronous and leaves the map clear and the stack empty, no clearing
// pass. A result held by out_stall holds the next item only in its posting cycle.
module maze_dfs_carver (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mdc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mdc_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mdc_pkg::CFG_W-1:0] cfg_data
);
  import mdc_pkg::*;

  localparam logic [MAX_WIDTH-1:0] ROW_ONE = {{(MAX_WIDTH-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW_RD,
    S_DRAW_WR,
    S_CHK0,
    S_CHK1,
    S_CHK2,
    S_CHK3,
    S_POP_RD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic          ok;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
  } nbr_t;

  // Neighbour of (x,y) towards d, with in-grid flag
  function automatic nbr_t nbr_of(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                  input logic [1:0] d, input logic [CFG_W-1:0] w,
                                  input logic [CFG_W-1:0] h);
    logic [CFG_W-1:0] ex;
    logic [CFG_W-1:0] ey;
    logic             bound_ok;
    nbr_t             r;
    ex       = CFG_W'(x);
    ey       = CFG_W'(y);
    bound_ok = 1'b1;
    case (d)
      DIR_RIGHT: ex = ex + CFG_W'(1);
      DIR_LEFT: begin
        bound_ok = (x != '0);
        ex       = ex - CFG_W'(1);
      end
      DIR_DOWN: ey = ey + CFG_W'(1);
      default: begin
        bound_ok = (y != '0);
        ey       = ey - CFG_W'(1);
      end
    endcase
    r.ok = bound_ok && (ex < w) && (ey < h);
    r.nx = ex[XW-1:0];
    r.ny = ey[YW-1:0];
    return r;
  endfunction

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_w_r, cfg_w_nxt;
  logic [CFG_W-1:0]   cfg_h_r, cfg_h_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [XW-1:0]      top_x_r, top_x_nxt;
  logic [YW-1:0]      top_y_r, top_y_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [XW-1:0]      nx_r, nx_nxt;
  logic [YW-1:0]      ny_r, ny_nxt;
  logic               mv_any_r, mv_any_nxt;
  logic               res_carved_r, res_carved_nxt;
  logic [XW-1:0]      res_fx_r, res_fx_nxt;
  logic [YW-1:0]      res_fy_r, res_fy_nxt;
  logic [1:0]         res_side_r, res_side_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [CFG_W-1:0]   w_eff;
  logic [CFG_W-1:0]   h_eff;
  logic               in_acc;
  logic               out_take;
  logic [CNT_W-1:0]   cnt_dec;
  nbr_t               nb_draw, nb_r, nb_l, nb_d, nb_u;

  vis_req_t           vis_req;
  logic [MAX_WIDTH-1:0] vis_row;

  logic               stk_we;
  logic [AW-1:0]      stk_waddr;
  logic [AW-1:0]      stk_wdata;
  logic               stk_re;
  logic [AW-1:0]      stk_raddr;
  logic [AW-1:0]      stk_rdata;

  mdc_visited u_visited (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (vis_req),
    .rd_row_q (vis_row)
  );

  // Cell stack: entry holds {x, y}
  mdc_ram #(
    .DEPTH (CELLS),
    .WIDTH (AW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Clamp grid size to 1..max
  assign w_eff = (cfg_w_r == '0) ? CFG_W'(1) :
                 (cfg_w_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_w_r;
  assign h_eff = (cfg_h_r == '0) ? CFG_W'(1) :
                 (cfg_h_r > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_h_r;

  // Neighbours of the top cell
  assign nb_draw = nbr_of(top_x_r, top_y_r, dir_r, w_eff, h_eff);
  assign nb_r    = nbr_of(top_x_r, top_y_r, DIR_RIGHT, w_eff, h_eff);
  assign nb_l    = nbr_of(top_x_r, top_y_r, DIR_LEFT, w_eff, h_eff);
  assign nb_d    = nbr_of(top_x_r, top_y_r, DIR_DOWN, w_eff, h_eff);
  assign nb_u    = nbr_of(top_x_r, top_y_r, DIR_UP, w_eff, h_eff);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: bitmap read-modify-write, neighbour check, pops
  always_comb begin
    state_nxt      = state_r;
    cfg_w_nxt      = cfg_w_r;
    cfg_h_nxt      = cfg_h_r;
    cnt_nxt        = cnt_r;
    top_x_nxt      = top_x_r;
    top_y_nxt      = top_y_r;
    dir_nxt        = dir_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    mv_any_nxt     = mv_any_r;
    res_carved_nxt = res_carved_r;
    res_fx_nxt     = res_fx_r;
    res_fy_nxt     = res_fy_r;
    res_side_nxt   = res_side_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    vis_req        = '0;
    stk_we         = 1'b0;
    stk_waddr      = '0;
    stk_wdata      = '0;
    stk_re         = 1'b0;
    stk_raddr      = '0;

    // Register writes
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_w_nxt = cfg_data;
        REG_HEIGHT: cfg_h_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_carved_nxt = 1'b0;
          res_fx_nxt     = '0;
          res_fy_nxt     = '0;
          res_side_nxt   = '0;
          if (in_data.cmd == CMD_RESTART) begin
            // clear map, visit and push cell 0
            vis_req.clr     = 1'b1;
            vis_req.wr_en   = 1'b1;
            vis_req.wr_row  = '0;
            vis_req.wr_data = ROW_ONE;
            stk_we          = 1'b1;
            stk_waddr       = '0;
            stk_wdata       = '0;
            cnt_nxt         = CNT_W'(1);
            top_x_nxt       = '0;
            top_y_nxt       = '0;
            state_nxt       = S_CHK0;
          end else if (cnt_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            dir_nxt   = in_data.direction;
            state_nxt = S_DRAW_RD;
          end
        end
      end

      S_DRAW_RD: begin
        if (nb_draw.ok) begin
          vis_req.rd_en  = 1'b1;
          vis_req.rd_row = nb_draw.ny;
          nx_nxt         = nb_draw.nx;
          ny_nxt         = nb_draw.ny;
          state_nxt      = S_DRAW_WR;
        end else begin
          state_nxt = S_CHK0;
        end
      end

      S_DRAW_WR: begin
        if (!vis_row[nx_r]) begin
          // carve: mark, push, report
          vis_req.wr_en   = 1'b1;
          vis_req.wr_row  = ny_r;
          vis_req.wr_data = vis_row | (ROW_ONE << nx_r);
          res_carved_nxt  = 1'b1;
          res_fx_nxt      = top_x_r;
          res_fy_nxt      = top_y_r;
          res_side_nxt    = dir_r;
          if (cnt_r < CNT_W'(CELLS)) begin
            stk_we    = 1'b1;
            stk_waddr = cnt_r[AW-1:0];
            stk_wdata = {nx_r, ny_r};
            cnt_nxt   = cnt_r + CNT_W'(1);
            top_x_nxt = nx_r;
            top_y_nxt = ny_r;
          end
        end
        state_nxt = S_CHK0;
      end

      S_CHK0: begin
        vis_req.rd_en  = 1'b1;
        vis_req.rd_row = top_y_r;
        state_nxt      = S_CHK1;
      end

      S_CHK1: begin
        // own row: right and left
        mv_any_nxt     = (nb_r.ok && !vis_row[nb_r.nx]) || (nb_l.ok && !vis_row[nb_l.nx]);
        vis_req.rd_en  = 1'b1;
        vis_req.rd_row = nb_d.ny;
        state_nxt      = S_CHK2;
      end

      S_CHK2: begin
        mv_any_nxt     = mv_any_r || (nb_d.ok && !vis_row[nb_d.nx]);
        vis_req.rd_en  = 1'b1;
        vis_req.rd_row = nb_u.ny;
        state_nxt      = S_CHK3;
      end

      S_CHK3: begin
        if (mv_any_r || (nb_u.ok && !vis_row[nb_u.nx])) begin
          state_nxt = S_FIN;
        end else begin
          // dead end: pop and fetch the new top
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            state_nxt = S_FIN;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = cnt_dec[AW-1:0] - AW'(1);
            state_nxt = S_POP_RD;
          end
        end
      end

      S_POP_RD: begin
        top_x_nxt = stk_rdata[AW-1 -: XW];
        top_y_nxt = stk_rdata[YW-1:0];
        state_nxt = S_CHK0;
      end

      S_FIN: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.carved    = res_carved_r;
          out_data_nxt.from_x    = res_fx_r;
          out_data_nxt.from_y    = res_fy_r;
          out_data_nxt.open_side = res_side_r;
          out_data_nxt.done_res  = (cnt_r == '0);
          state_nxt              = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= CFG_W'(8);
      cfg_h_r     <= CFG_W'(8);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_w_r      <= cfg_w_nxt;
      cfg_h_r      <= cfg_h_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      top_x_r      <= top_x_nxt;
      top_y_r      <= top_y_nxt;
      dir_r        <= dir_nxt;
      nx_r         <= nx_nxt;
      ny_r         <= ny_nxt;
      mv_any_r     <= mv_any_nxt;
      res_carved_r <= res_carved_nxt;
      res_fx_r     <= res_fx_nxt;
      res_fy_r     <= res_fy_nxt;
      res_side_r   <= res_side_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

endmodule

[rtl/mdc_ram.sv]
// mdc_ram: simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module mdc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mdc_visited.sv]
// mdc_visited: visited bitmap held as rows in a RAM, with one valid flop per
// row so a restart clears the whole map without a pass over the RAM.
// Depends on mdc_pkg and mdc_ram.
module mdc_visited (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mdc_pkg::vis_req_t            req,
  output logic [mdc_pkg::MAX_WIDTH-1:0] rd_row_q
);
  import mdc_pkg::*;

  logic [MAX_HEIGHT-1:0] row_vld_r;
  logic [MAX_HEIGHT-1:0] row_vld_nxt;
  logic                  vld_q_r;
  logic [MAX_WIDTH-1:0]  ram_q;

  mdc_ram #(
    .DEPTH (MAX_HEIGHT),
    .WIDTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_row),
    .wdata (req.wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_row),
    .rdata (ram_q)
  );

  // Row valid bits: clear on restart, set on any row write
  always_comb begin
    row_vld_nxt = row_vld_r;
    if (req.clr) begin
      row_vld_nxt = '0;
    end
    if (req.wr_en) begin
      row_vld_nxt[req.wr_row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      row_vld_r <= row_vld_nxt;
      if (req.rd_en) begin
        vld_q_r <= row_vld_r[req.rd_row];
      end
    end
  end

  // A row never written since restart reads as all clear
  assign rd_row_q = vld_q_r ? ram_q : '0;

endmodule
